/* hdl/fre_pkg.sv */
package fre_pkg;

  localparam int unsigned CONTEXTS    = 5;
  localparam int unsigned MAX_FRAGS   = 68;
  localparam int unsigned FRAG_BYTES  = 30;
  localparam int unsigned CTX_W       = (CONTEXTS > 1) ? $clog2(CONTEXTS) : 1;
  localparam int unsigned CTX_ROW     = MAX_FRAGS * FRAG_BYTES;
  localparam int unsigned STORE_DEPTH = CONTEXTS * CTX_ROW;
  localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
  localparam logic [15:0] TIMEOUT_RST = 16'd5000;

  localparam logic [1:0] CMD_TICK    = 2'd0;
  localparam logic [1:0] CMD_BYTE    = 2'd1;
  localparam logic [1:0] CMD_READ    = 2'd2;
  localparam logic [1:0] CMD_RELEASE = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_STORED   = 3'd1;
  localparam logic [2:0] ST_COMPLETE = 3'd2;
  localparam logic [2:0] ST_DUP      = 3'd3;
  localparam logic [2:0] ST_NO_CTX   = 3'd4;
  localparam logic [2:0] ST_BAD_NUM  = 3'd5;
  localparam logic [2:0] ST_DROPPED  = 3'd6;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  pkt_tag;
    logic [6:0]  fragment_number;
    logic        is_last_fragment;
    logic [4:0]  byte_offset;
    logic [7:0]  data_byte;
    logic [2:0]  read_context;
    logic [10:0] read_address;
  } item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  context_index;
    logic [7:0]  done_pkt_tag;
    logic [10:0] packet_length;
    logic [2:0]  expired_count;
  } result_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        wdata;
  } ram_req_t;

endpackage

/* hdl/fre_ram.sv */
module fre_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* hdl/fre_ctx.sv */
module fre_ctx (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [15:0]      cfg_wdata_i,
  input  logic             item_valid_i,
  input  fre_pkg::item_t   item_i,
  output fre_pkg::result_t result_o,
  output fre_pkg::ram_req_t ram_req_o
);
  import fre_pkg::*;

  logic [CONTEXTS-1:0]  busy_q, busy_d, done_q, done_d;
  logic [7:0]           packet_q [CONTEXTS];
  logic [7:0]           packet_d [CONTEXTS];
  logic [6:0]           total_q  [CONTEXTS];
  logic [6:0]           total_d  [CONTEXTS];
  logic [15:0]          age_q    [CONTEXTS];
  logic [15:0]          age_d    [CONTEXTS];
  logic [MAX_FRAGS-1:0] seen_q   [CONTEXTS];
  logic [MAX_FRAGS-1:0] seen_d   [CONTEXTS];
  logic                 open_vld_q, open_vld_d;
  logic [CTX_W-1:0]     open_ctx_q, open_ctx_d;
  logic [6:0]           open_frag_q, open_frag_d;
  logic [15:0]          timeout_q;

  logic                 match_hit, free_hit, alloc, complete, rc_ok, rd_ok, go;
  logic [CTX_W-1:0]     match_idx, free_idx, ctx_sel, rc_idx;
  logic [MAX_FRAGS-1:0] row_eff, row_new, frag_bit, total_mask;
  logic [6:0]           total_eff;
  logic [15:0]          age_n;
  logic [4:0]           exp_cnt;

  // Parallel compare over contexts, lowest index wins
  always_comb begin
    match_hit = 1'b0;
    match_idx = '0;
    free_hit  = 1'b0;
    free_idx  = '0;
    for (int i = CONTEXTS - 1; i >= 0; i--) begin
      if (busy_q[i] && !done_q[i] && packet_q[i] == item_i.pkt_tag) begin
        match_hit = 1'b1;
        match_idx = CTX_W'(i);
      end
      if (!busy_q[i]) begin
        free_hit = 1'b1;
        free_idx = CTX_W'(i);
      end
    end
  end

  assign alloc   = (item_i.byte_offset == 5'd0) && !match_hit;
  assign ctx_sel = (item_i.byte_offset != 5'd0) ? open_ctx_q :
                   (match_hit ? match_idx : free_idx);
  assign row_eff  = alloc ? '0 : seen_q[ctx_sel];
  assign frag_bit = MAX_FRAGS'(1) << item_i.fragment_number;
  assign row_new  = row_eff | frag_bit;
  assign total_eff = item_i.is_last_fragment ? 7'(item_i.fragment_number + 7'd1) :
                     (alloc ? 7'd0 : total_q[ctx_sel]);

  always_comb begin
    for (int j = 0; j < MAX_FRAGS; j++) begin
      total_mask[j] = (j < int'(total_eff));
    end
  end

  assign complete = (total_eff != 7'd0) && (&(row_new | ~total_mask));

  assign rc_idx = CTX_W'(item_i.read_context);
  assign rc_ok  = (int'(item_i.read_context) < CONTEXTS);
  assign rd_ok  = rc_ok && done_q[rc_idx] &&
                  (int'(item_i.read_address) < int'(total_q[rc_idx]) * FRAG_BYTES) &&
                  (int'(item_i.read_address) < CTX_ROW);

  always_comb begin
    busy_d      = busy_q;
    done_d      = done_q;
    packet_d    = packet_q;
    total_d     = total_q;
    age_d       = age_q;
    seen_d      = seen_q;
    open_vld_d  = open_vld_q;
    open_ctx_d  = open_ctx_q;
    open_frag_d = open_frag_q;
    result_o    = '0;
    ram_req_o   = '0;
    exp_cnt     = '0;
    age_n       = '0;
    go          = 1'b0;
    if (item_valid_i) begin
      unique case (item_i.command)
        CMD_TICK: begin
          for (int i = 0; i < CONTEXTS; i++) begin
            if (busy_q[i] && !done_q[i]) begin
              age_n = (age_q[i] == 16'hFFFF) ? age_q[i] : age_q[i] + 16'd1;
              age_d[i] = age_n;
              if (age_n > timeout_q) begin
                busy_d[i] = 1'b0;
                exp_cnt   = exp_cnt + 5'd1;
                if (open_vld_q && open_ctx_q == CTX_W'(i)) begin
                  open_vld_d = 1'b0;
                end
              end
            end
          end
          result_o.expired_count = (exp_cnt > 5'd7) ? 3'd7 : exp_cnt[2:0];
        end
        CMD_BYTE: begin
          if (int'(item_i.byte_offset) >= FRAG_BYTES) begin
            result_o.status = ST_DROPPED;
          end else if (item_i.byte_offset == 5'd0) begin
            open_vld_d = 1'b0;
            if (int'(item_i.fragment_number) >= MAX_FRAGS) begin
              result_o.status = ST_BAD_NUM;
            end else if (!match_hit && !free_hit) begin
              result_o.status = ST_NO_CTX;
            end else begin
              if (alloc) begin
                seen_d[ctx_sel]   = '0;
                busy_d[ctx_sel]   = 1'b1;
                done_d[ctx_sel]   = 1'b0;
                packet_d[ctx_sel] = item_i.pkt_tag;
                total_d[ctx_sel]  = 7'd0;
                age_d[ctx_sel]    = 16'd0;
              end
              result_o.context_index = 3'(ctx_sel);
              if ((row_eff & frag_bit) != '0) begin
                result_o.status = ST_DUP;
              end else begin
                open_vld_d  = 1'b1;
                open_ctx_d  = ctx_sel;
                open_frag_d = item_i.fragment_number;
                go          = 1'b1;
              end
            end
          end else begin
            if (open_vld_q && open_frag_q == item_i.fragment_number &&
                busy_q[open_ctx_q] && !done_q[open_ctx_q] &&
                packet_q[open_ctx_q] == item_i.pkt_tag) begin
              result_o.context_index = 3'(ctx_sel);
              go = 1'b1;
            end else begin
              result_o.status = ST_DROPPED;
            end
          end
          if (go) begin
            ram_req_o.we    = 1'b1;
            ram_req_o.addr  = ADDR_W'(int'(ctx_sel) * CTX_ROW +
                              int'(item_i.fragment_number) * FRAG_BYTES +
                              int'(item_i.byte_offset));
            ram_req_o.wdata = item_i.data_byte;
            result_o.status = ST_STORED;
            // Final byte: mark fragment received, check for a whole packet
            if (int'(item_i.byte_offset) == FRAG_BYTES - 1) begin
              open_vld_d       = 1'b0;
              seen_d[ctx_sel]  = row_new;
              age_d[ctx_sel]   = 16'd0;
              total_d[ctx_sel] = total_eff;
              if (complete) begin
                done_d[ctx_sel]          = 1'b1;
                result_o.status          = ST_COMPLETE;
                result_o.done_pkt_tag    = item_i.pkt_tag;
                result_o.packet_length   = 11'(int'(total_eff) * FRAG_BYTES);
              end
            end
          end
        end
        CMD_READ: begin
          result_o.context_index = item_i.read_context;
          if (rd_ok) begin
            ram_req_o.re   = 1'b1;
            ram_req_o.addr = ADDR_W'(int'(rc_idx) * CTX_ROW + int'(item_i.read_address));
          end else begin
            result_o.status = ST_DROPPED;
          end
        end
        CMD_RELEASE: begin
          result_o.context_index = item_i.read_context;
          if (rc_ok) begin
            busy_d[rc_idx] = 1'b0;
            done_d[rc_idx] = 1'b0;
            if (open_vld_q && open_ctx_q == rc_idx) begin
              open_vld_d = 1'b0;
            end
          end else begin
            result_o.status = ST_DROPPED;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= '0;
      done_q      <= '0;
      open_vld_q  <= 1'b0;
      open_ctx_q  <= '0;
      open_frag_q <= '0;
      timeout_q   <= TIMEOUT_RST;
      for (int i = 0; i < CONTEXTS; i++) begin
        packet_q[i] <= '0;
        total_q[i]  <= '0;
        age_q[i]    <= '0;
        seen_q[i]   <= '0;
      end
    end else begin
      busy_q      <= busy_d;
      done_q      <= done_d;
      open_vld_q  <= open_vld_d;
      open_ctx_q  <= open_ctx_d;
      open_frag_q <= open_frag_d;
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
      packet_q <= packet_d;
      total_q  <= total_d;
      age_q    <= age_d;
      seen_q   <= seen_d;
    end
  end

  for (genvar g = 0; g < CONTEXTS; g++) begin : g_chk
    a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
      done_q[g] |-> busy_q[g])
      else $error("context done without being busy");
  end

  a_open_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_vld_q |-> (busy_q[open_ctx_q] && !done_q[open_ctx_q]))
    else $error("open fragment points at a context that is not collecting");

endmodule

/* hdl/fragment_reassembly_engine_unit.sv */
// Channel   | Dir | tdata (low bit up)                               | tuser   | tlast
// s_axis    | in  | pkt_tag, fragment_number, byte_offset,           | command | is_last_fragment
//           |     | data_byte, read_context, read_address            |         |
// m_axis    | out | context_index, done_pkt_tag,                     | status  | -
//           |     | packet_length, read_data, expired_count          |         |
// cfg       | in  | timeout_ticks, written when cfg_we_i is high     |         |
//
// Tick, payload and release requests go straight to the result register; a read first passes
// through the S_READ state, which waits on the registered read port of the payload RAM.
// A new request is taken while no read is in flight and the result register is empty or being drained.
// Reset is asynchronous and clears all context state; the payload RAM is not cleared.
// A result that is not accepted holds off the next request; a read also holds it
// off while it waits in the S_READ state for the RAM.
module fragment_reassembly_engine_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // pkt_tag[7:0], fragment_number[14:8], byte_offset[19:15], data_byte[27:20],
  // read_context[30:28], read_address[41:31], zero fill
  input  logic [47:0] s_axis_tdata_i,
  // command[1:0]
  input  logic [1:0]  s_axis_tuser_i,
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // context_index[2:0], done_pkt_tag[10:3], packet_length[21:11],
  // read_data[29:22], expired_count[32:30], zero fill
  output logic [39:0] m_axis_tdata_o,
  // status[2:0]
  output logic [2:0]  m_axis_tuser_o
);
  import fre_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic     state_q, state_d;
  logic     fire;
  item_t    item;
  result_t  res, res_q, res_d;
  ram_req_t req;
  logic     m_valid_q, m_valid_d;
  logic [7:0] rdata, rdata_q, rdata_d;

  assign s_axis_tready_o = (state_q == S_IDLE) && (!m_valid_q || m_axis_tready_i);
  assign fire = s_axis_tvalid_i && s_axis_tready_o;

  assign item.command          = s_axis_tuser_i;
  assign item.pkt_tag          = s_axis_tdata_i[7:0];
  assign item.fragment_number  = s_axis_tdata_i[14:8];
  assign item.is_last_fragment = s_axis_tlast_i;
  assign item.byte_offset      = s_axis_tdata_i[19:15];
  assign item.data_byte        = s_axis_tdata_i[27:20];
  assign item.read_context     = s_axis_tdata_i[30:28];
  assign item.read_address     = s_axis_tdata_i[41:31];

  fre_ctx u_ctx (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .item_valid_i (fire),
    .item_i       (item),
    .result_o     (res),
    .ram_req_o    (req)
  );

  fre_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (req.we),
    .waddr_i (req.addr),
    .wdata_i (req.wdata),
    .re_i    (req.re),
    .raddr_i (req.addr),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d   = state_q;
    m_valid_d = m_valid_q;
    res_d     = res_q;
    rdata_d   = rdata_q;
    if (m_valid_q && m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (fire) begin
          res_d   = res;
          rdata_d = 8'd0;
          if (req.re) begin
            state_d = S_READ;
          end else begin
            m_valid_d = 1'b1;
          end
        end
      end
      S_READ: begin
        // RAM data is valid now: finish the read request
        rdata_d   = rdata;
        m_valid_d = 1'b1;
        state_d   = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q   <= res_d;
    rdata_q <= rdata_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tuser_o  = res_q.status;
  assign m_axis_tdata_o  = {7'd0, res_q.expired_count, rdata_q, res_q.packet_length,
                            res_q.done_pkt_tag, res_q.context_index};

  a_read_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && req.re) |=> (state_q == S_READ) ##1 m_axis_tvalid_o)
    else $error("read request did not return a result two cycles later");

  a_read_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |-> !m_axis_tvalid_o)
    else $error("result register busy while a read is in flight");

endmodule

/* sim/fragment_reassembly_engine_unit_tb.sv */
module fragment_reassembly_engine_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fre_pkg::*;

  localparam int unsigned IDLE_LIMIT = 20000;
  localparam int unsigned RANDOM_ITEMS = 700;

  typedef struct {
    logic [2:0]  status;
    logic [2:0]  context_index;
    logic [7:0]  done_pkt_tag;
    logic [10:0] packet_length;
    logic [7:0]  read_data;
    logic [2:0]  expired_count;
    bit          typed;
    logic [2:0]  typed_status;
  } outcome_t;

  typedef struct {
    logic [1:0]  command;
    logic [7:0]  pkt_tag;
    logic [6:0]  fragment_number;
    logic        is_last_fragment;
    logic [4:0]  byte_offset;
    logic [7:0]  data_byte;
    logic [2:0]  read_context;
    logic [10:0] read_address;
  } request_t;

  // One row of the directed table; has_fixed marks a typed-in status.
  typedef struct {
    request_t   req;
    bit         has_fixed;
    logic [2:0] fixed_status;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [47:0] s_axis_tdata_i = '0;
  logic [1:0]  s_axis_tuser_i = '0;
  logic        s_axis_tlast_i = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [39:0] m_axis_tdata_o;
  logic [2:0]  m_axis_tuser_o;

  fragment_reassembly_engine_unit u_top (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Predictor state
  logic [7:0]  pay_mem [STORE_DEPTH];
  bit          pay_written [STORE_DEPTH];
  bit          seen_bits [CONTEXTS*MAX_FRAGS];
  bit          ctx_busy [CONTEXTS];
  bit          ctx_done [CONTEXTS];
  logic [7:0]  ctx_pkt [CONTEXTS];
  logic [6:0]  ctx_total [CONTEXTS];
  logic [15:0] ctx_age [CONTEXTS];
  bit          open_valid;
  int unsigned open_ctx;
  logic [6:0]  open_frag;
  logic [15:0] timeout_reg;

  outcome_t expected_q[$];
  int unsigned errors = 0;
  int unsigned requests_sent = 0;
  int unsigned results_seen = 0;
  int unsigned completes_seen = 0;
  int unsigned idle_cycles = 0;
  bit          rx_stall_mode = 1'b0;

  function automatic outcome_t predict_outcome(request_t r);
    outcome_t o;
    int unsigned ctx, n, total, base;
    bit all_in;
    o = '{default: '0};
    case (r.command)
      CMD_TICK: begin
        n = 0;
        for (int i = 0; i < CONTEXTS; i++) begin
          if (ctx_busy[i] && !ctx_done[i]) begin
            if (ctx_age[i] != 16'hFFFF) ctx_age[i]++;
            if (ctx_age[i] > timeout_reg) begin
              ctx_busy[i] = 0;
              n++;
              if (open_valid && open_ctx == i) open_valid = 0;
            end
          end
        end
        o.expired_count = (n > 7) ? 3'd7 : n[2:0];
        o.status = ST_OK;
      end
      CMD_BYTE: begin
        if (r.byte_offset >= FRAG_BYTES) begin
          o.status = ST_DROPPED;
          return o;
        end
        if (r.byte_offset == 0) begin
          open_valid = 0;
          if (r.fragment_number >= MAX_FRAGS) begin
            o.status = ST_BAD_NUM;
            return o;
          end
          ctx = CONTEXTS;
          for (int i = 0; i < CONTEXTS; i++)
            if (ctx == CONTEXTS && ctx_busy[i] && !ctx_done[i] && ctx_pkt[i] == r.pkt_tag)
              ctx = i;
          if (ctx == CONTEXTS) begin
            for (int i = 0; i < CONTEXTS; i++)
              if (ctx == CONTEXTS && !ctx_busy[i]) ctx = i;
            if (ctx == CONTEXTS) begin
              o.status = ST_NO_CTX;
              return o;
            end
            for (int f = 0; f < MAX_FRAGS; f++) seen_bits[ctx*MAX_FRAGS+f] = 0;
            ctx_busy[ctx] = 1;
            ctx_done[ctx] = 0;
            ctx_pkt[ctx] = r.pkt_tag;
            ctx_total[ctx] = '0;
            ctx_age[ctx] = '0;
          end
          o.context_index = ctx[2:0];
          if (seen_bits[ctx*MAX_FRAGS+r.fragment_number]) begin
            o.status = ST_DUP;
            return o;
          end
          open_valid = 1;
          open_ctx = ctx;
          open_frag = r.fragment_number;
        end else begin
          if (!open_valid || open_frag != r.fragment_number || !ctx_busy[open_ctx] ||
              ctx_done[open_ctx] || ctx_pkt[open_ctx] != r.pkt_tag) begin
            o.status = ST_DROPPED;
            return o;
          end
          ctx = open_ctx;
          o.context_index = ctx[2:0];
        end
        base = (ctx*MAX_FRAGS + r.fragment_number)*FRAG_BYTES + r.byte_offset;
        pay_mem[base] = r.data_byte;
        pay_written[base] = 1;
        o.status = ST_STORED;
        if (r.byte_offset == FRAG_BYTES-1) begin
          open_valid = 0;
          seen_bits[ctx*MAX_FRAGS+r.fragment_number] = 1;
          ctx_age[ctx] = '0;
          if (r.is_last_fragment) ctx_total[ctx] = r.fragment_number + 7'd1;
          total = ctx_total[ctx];
          if (total != 0) begin
            all_in = 1;
            for (int f = 0; f < total && f < MAX_FRAGS; f++)
              if (!seen_bits[ctx*MAX_FRAGS+f]) all_in = 0;
            if (all_in) begin
              ctx_done[ctx] = 1;
              o.status = ST_COMPLETE;
              o.done_pkt_tag = ctx_pkt[ctx];
              o.packet_length = 11'(total*FRAG_BYTES);
            end
          end
        end
      end
      CMD_READ: begin
        o.context_index = r.read_context;
        if (r.read_context < CONTEXTS && ctx_done[r.read_context] &&
            r.read_address < ctx_total[r.read_context]*FRAG_BYTES)
          o.read_data = pay_mem[r.read_context*CTX_ROW + r.read_address];
        else
          o.status = ST_DROPPED;
      end
      default: begin
        o.context_index = r.read_context;
        if (r.read_context < CONTEXTS) begin
          ctx_busy[r.read_context] = 0;
          ctx_done[r.read_context] = 0;
          if (open_valid && open_ctx == r.read_context) open_valid = 0;
        end else begin
          o.status = ST_DROPPED;
        end
      end
    endcase
    return o;
  endfunction

  // Keep reads on bytes already written; others go to a written byte, or past the end if none is.
  function automatic request_t legalize_read(request_t r);
    int unsigned lim;
    if (r.command != CMD_READ || r.read_context >= CONTEXTS || !ctx_done[r.read_context])
      return r;
    lim = ctx_total[r.read_context]*FRAG_BYTES;
    if (r.read_address >= lim) return r;
    if (!pay_written[r.read_context*CTX_ROW + r.read_address]) begin
      for (int a = 0; a < lim; a++)
        if (pay_written[r.read_context*CTX_ROW + a]) begin
          r.read_address = a;
          return r;
        end
      r.read_address = 11'(lim + $urandom_range(0, 50));
    end
    return r;
  endfunction

  task automatic send_request(request_t r);
    r = legalize_read(r);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= r.command;
    s_axis_tlast_i  <= r.is_last_fragment;
    s_axis_tdata_i  <= {6'd0, r.read_address, r.read_context, r.data_byte, r.byte_offset,
                        r.fragment_number, r.pkt_tag};
    do @(posedge clk_i); while (!s_axis_tready_o);
    expected_q.push_back(predict_outcome(r));
    requests_sent++;
  endtask

  task automatic sender_gap();
    int unsigned g;
    g = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
    if (g != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic drain_and_write(logic [15:0] value);
    s_axis_tvalid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    timeout_reg = value;
  endtask

  // Result checker
  always @(posedge clk_i) begin
    outcome_t e;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        $error("result with no request pending");
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (e.typed && m_axis_tuser_o !== e.typed_status) begin
          $error("status exp %0d got %0d (table)", e.typed_status, m_axis_tuser_o); errors++;
        end
        if (m_axis_tuser_o !== e.status) begin
          $error("status exp %0d got %0d", e.status, m_axis_tuser_o); errors++;
        end
        if (m_axis_tdata_o[2:0] !== e.context_index) begin
          $error("context_index exp %0d got %0d", e.context_index, m_axis_tdata_o[2:0]);
          errors++;
        end
        if (m_axis_tdata_o[10:3] !== e.done_pkt_tag) begin
          $error("done_pkt_tag exp %0d got %0d", e.done_pkt_tag,
                 m_axis_tdata_o[10:3]); errors++;
        end
        if (m_axis_tdata_o[21:11] !== e.packet_length) begin
          $error("packet_length exp %0d got %0d", e.packet_length, m_axis_tdata_o[21:11]);
          errors++;
        end
        if (m_axis_tdata_o[29:22] !== e.read_data) begin
          $error("read_data exp %0d got %0d", e.read_data, m_axis_tdata_o[29:22]); errors++;
        end
        if (m_axis_tdata_o[32:30] !== e.expired_count) begin
          $error("expired_count exp %0d got %0d", e.expired_count, m_axis_tdata_o[32:30]);
          errors++;
        end
        if (e.status == ST_COMPLETE) completes_seen++;
      end
    end
  end

  // Receiver stall pattern: alternate stretches of free flow and random stalls
  always @(posedge clk_i) begin
    if ($urandom_range(0, 63) == 0) rx_stall_mode <= ~rx_stall_mode;
    m_axis_tready_i <= rx_stall_mode ? ($urandom_range(0, 2) != 0) : 1'b1;
  end

  // Watchdog on cycles with nothing accepted
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
        cfg_we_i)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("fragment_reassembly_engine_unit: mismatch");
      $finish;
    end
  end

  function automatic request_t mk(logic [1:0] cmd, logic [7:0] id, logic [6:0] frag,
                                  logic last, logic [4:0] off, logic [7:0] d,
                                  logic [2:0] rc, logic [10:0] ra);
    request_t r;
    r.command = cmd; r.pkt_tag = id; r.fragment_number = frag;
    r.is_last_fragment = last; r.byte_offset = off; r.data_byte = d;
    r.read_context = rc; r.read_address = ra;
    return r;
  endfunction

  // Stream one fragment; when noisy, a byte is sometimes corrupted and a middle byte sometimes skipped.
  task automatic send_fragment(logic [7:0] id, logic [6:0] frag, logic last, bit noisy);
    request_t r;
    for (int off = 0; off < FRAG_BYTES; off++) begin
      r = mk(CMD_BYTE, id, frag, last, off[4:0], 8'($urandom), 3'($urandom), 11'($urandom));
      if (noisy && $urandom_range(0, 40) == 0) r.pkt_tag = 8'($urandom);
      if (noisy && $urandom_range(0, 60) == 0) r.byte_offset = 5'($urandom_range(30, 31));
      if (!(noisy && off != 0 && off != FRAG_BYTES-1 && $urandom_range(0, 30) == 0))
        send_request(r);
      sender_gap();
    end
  endtask

  task automatic read_out(int unsigned c);
    int unsigned lim;
    lim = ctx_total[c]*FRAG_BYTES;
    repeat ($urandom_range(2, 8))
      send_request(mk(CMD_READ, 8'($urandom), 7'($urandom), 1'($urandom), 5'($urandom),
                      8'($urandom), c[2:0], 11'($urandom_range(0, lim + 5))));
    send_request(mk(CMD_READ, 0, 0, 0, 0, 0, c[2:0], 11'(lim - 1)));
    send_request(mk(CMD_READ, 0, 0, 0, 0, 0, c[2:0], 11'h7FF));
    if ($urandom_range(0, 5) != 0)
      send_request(mk(CMD_RELEASE, 8'($urandom), 0, 0, 0, 0, c[2:0], 11'($urandom)));
  endtask

  task automatic random_packet();
    logic [7:0] id;
    int unsigned nfr;
    id = 8'($urandom);
    nfr = ($urandom_range(0, 15) == 0) ? $urandom_range(4, 6) : $urandom_range(1, 3);
    for (int k = nfr-1; k >= 0; k--) begin
      send_fragment(id, k[6:0], k == nfr-1, 1'b1);
      if ($urandom_range(0, 8) == 0) send_fragment(id, k[6:0], k == nfr-1, 1'b0);
    end
    for (int c = 0; c < CONTEXTS; c++)
      if (ctx_done[c] && ctx_pkt[c] == id) read_out(c);
  endtask

  task automatic random_noise();
    request_t r;
    r = mk(2'($urandom), 8'($urandom), 7'($urandom), 1'($urandom), 5'($urandom),
           8'($urandom), 3'($urandom), 11'($urandom));
    if ($urandom_range(0, 1)) r.command = CMD_TICK;
    send_request(r);
    sender_gap();
  endtask

  row_t directed[$];

  initial begin
    int unsigned plan_idx;
    logic [15:0] plan [4] = '{16'd1, 16'd3, 16'd65535, 16'd40};
    for (int i = 0; i < STORE_DEPTH; i++) pay_written[i] = 0;
    for (int i = 0; i < CONTEXTS*MAX_FRAGS; i++) seen_bits[i] = 0;
    for (int i = 0; i < CONTEXTS; i++) begin
      ctx_busy[i] = 0; ctx_done[i] = 0; ctx_pkt[i] = '0; ctx_total[i] = '0; ctx_age[i] = '0;
    end
    open_valid = 0; open_ctx = 0; open_frag = '0;
    timeout_reg = TIMEOUT_RST;

    directed.push_back('{mk(CMD_TICK, 8'hFF, 7'h7F, 1, 5'd31, 8'hFF, 3'd7, 11'h7FF), 1, ST_OK});
    directed.push_back('{mk(CMD_BYTE, 8'h00, 7'd0, 0, 5'd31, 8'h00, 0, 0), 1, ST_DROPPED});
    directed.push_back('{mk(CMD_BYTE, 8'hFF, 7'd0, 0, 5'd30, 8'hFF, 0, 0), 1, ST_DROPPED});
    directed.push_back('{mk(CMD_BYTE, 8'h12, 7'd68, 0, 5'd0, 8'hAA, 0, 0), 1, ST_BAD_NUM});
    directed.push_back('{mk(CMD_BYTE, 8'h12, 7'd127, 1, 5'd0, 8'hAA, 0, 0), 1, ST_BAD_NUM});
    directed.push_back('{mk(CMD_BYTE, 8'h12, 7'd3, 0, 5'd5, 8'hAA, 0, 0), 1, ST_DROPPED});
    directed.push_back('{mk(CMD_READ, 0, 0, 0, 0, 0, 3'd7, 11'd0), 1, ST_DROPPED});
    directed.push_back('{mk(CMD_READ, 0, 0, 0, 0, 0, 3'd0, 11'd0), 1, ST_DROPPED});
    directed.push_back('{mk(CMD_RELEASE, 0, 0, 0, 0, 0, 3'd5, 11'd0), 1, ST_DROPPED});
    directed.push_back('{mk(CMD_RELEASE, 0, 0, 0, 0, 0, 3'd4, 11'd0), 1, ST_OK});
    // Five packets fill all contexts, a sixth finds none
    for (int i = 0; i < CONTEXTS; i++)
      directed.push_back('{mk(CMD_BYTE, 8'(8'h40 + i), 7'd67, 0, 5'd0, 8'h5A, 0, 0), 0, 0});
    directed.push_back('{mk(CMD_BYTE, 8'h99, 7'd0, 0, 5'd0, 8'h00, 0, 0), 1, ST_NO_CTX});
    directed.push_back('{mk(CMD_BYTE, 8'h44, 7'd67, 0, 5'd1, 8'h01, 0, 0), 1, ST_DROPPED});
    for (int i = 0; i < CONTEXTS; i++)
      directed.push_back('{mk(CMD_RELEASE, 0, 0, 0, 0, 0, i[2:0], 0), 1, ST_OK});

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) begin
      send_request(directed[i].req);
      if (directed[i].has_fixed) begin
        expected_q[$].typed = 1'b1;
        expected_q[$].typed_status = directed[i].fixed_status;
      end
    end
    // One full short packet with a last marker moved, a duplicate, and a header abandon
    send_fragment(8'h77, 7'd1, 1'b1, 1'b0);
    send_fragment(8'h77, 7'd1, 1'b1, 1'b0);
    send_request(mk(CMD_BYTE, 8'h77, 7'd0, 0, 5'd0, 8'h11, 0, 0));
    send_fragment(8'h77, 7'd0, 1'b1, 1'b0);
    send_fragment(8'h77, 7'd2, 1'b1, 1'b0);
    for (int c = 0; c < CONTEXTS; c++) if (ctx_done[c]) read_out(c);

    plan_idx = 0;
    while (requests_sent < RANDOM_ITEMS) begin
      if (requests_sent > 140*(plan_idx+1) && plan_idx < 4) begin
        drain_and_write(plan[plan_idx]);
        plan_idx++;
      end
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 6)) random_noise();
      end else begin
        random_packet();
        if ($urandom_range(0, 2) == 0)
          repeat ($urandom_range(1, timeout_reg < 20 ? 25 : 3))
            send_request(mk(CMD_TICK, 8'($urandom), 7'($urandom), 1'($urandom),
                            5'($urandom), 8'($urandom), 3'($urandom), 11'($urandom)));
      end
    end
    drain_and_write(TIMEOUT_RST);

    s_axis_tvalid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    $display("Covered %0d requests and %0d results, %0d packets completed,",
             requests_sent, results_seen, completes_seen);
    $display("across timeout settings of 1, 3, 40, 65535 and the reset value.");
    if (errors == 0 && expected_q.size() == 0)
      $display("fragment_reassembly_engine_unit: match");
    else
      $display("fragment_reassembly_engine_unit: mismatch");
    $finish;
  end

endmodule

/* files.f */
hdl/fre_pkg.sv
hdl/fre_ram.sv
hdl/fre_ctx.sv
hdl/fragment_reassembly_engine_unit.sv
sim/fragment_reassembly_engine_unit_tb.sv
